FILE: src/bmtp_pkg.sv
`default_nettype none
package bmtp_pkg;

  localparam int FracBitsDef = 16;
  localparam int ExpDepthDef = 256;
  localparam int ExpArgLimit = 32;
  localparam int Iq          = 30;
  localparam int AgeWidth    = 32;
  localparam int RateWidth   = 32;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusRateZero = 2'd1,
    StatusClamp    = 2'd2
  } status_e;

  typedef enum logic {
    CfgRate01 = 1'b0,
    CfgRate10 = 1'b1
  } cfg_idx_e;

  // exp(-u), u in q34.30 and result in q2.30, truncated taylor terms
  function automatic logic [31:0] exp_series(input logic [63:0] u);
    logic signed [63:0] acc;
    logic [63:0]        term;
    logic               stop;
    acc  = 64'sd1 <<< Iq;
    term = 64'd1 << Iq;
    stop = 1'b0;
    for (int i = 1; i < 40; i++) begin
      if (!stop) begin
        term = ((term * u) >> Iq) / 64'(i);
        if (term == 64'd0) begin
          stop = 1'b1;
        end else if (i[0]) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    return acc[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/bmtp_fifo.sv
`default_nettype none
module bmtp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/bmtp_pidiv.sv
`default_nettype none
module bmtp_pidiv import bmtp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [RateWidth-1:0] q01_i,
  input  wire logic [RateWidth-1:0] q10_i,
  output logic [FRAC_BITS:0]        pi0_o,
  output logic                      busy_o
);

  localparam int SumW = RateWidth + 1;
  localparam int NumW = RateWidth + FRAC_BITS + 1;
  localparam int CntW = $clog2(FRAC_BITS + 1);

  typedef enum logic {Idle, Run} state_e;

  state_e             state_q;
  logic               pend_q;
  logic [SumW-1:0]    sum_q;
  logic [SumW:0]      rem_q;
  logic [FRAC_BITS:0] nlo_q, quo_q, pi0_q;
  logic [CntW-1:0]    cnt_q;

  logic [SumW-1:0]    sum_ld;
  logic [NumW-1:0]    num_ld;
  logic [SumW:0]      rem_sh, rem_d;
  logic               bit_d;

  always_comb begin
    sum_ld = {1'b0, q01_i} + {1'b0, q10_i};
    num_ld = {1'b0, q10_i, {FRAC_BITS{1'b0}}} + NumW'(sum_ld >> 1);
    rem_sh = {rem_q[SumW-1:0], nlo_q[FRAC_BITS]};
    bit_d  = (rem_sh >= {1'b0, sum_q});
    rem_d  = bit_d ? rem_sh - {1'b0, sum_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      pend_q  <= 1'b1;
      cnt_q   <= '0;
      pi0_q   <= '0;
    end else begin
      if (start_i) begin
        pend_q <= 1'b1;
      end
      unique case (state_q)
        Idle: begin
          if (pend_q && !start_i) begin
            pend_q  <= 1'b0;
            state_q <= Run;
            sum_q   <= sum_ld;
            rem_q   <= (SumW + 1)'(num_ld >> (FRAC_BITS + 1));
            nlo_q   <= num_ld[FRAC_BITS:0];
            cnt_q   <= CntW'(FRAC_BITS);
          end
        end
        Run: begin
          rem_q <= rem_d;
          nlo_q <= nlo_q << 1;
          quo_q <= {quo_q[FRAC_BITS-1:0], bit_d};
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            pi0_q   <= {quo_q[FRAC_BITS-1:0], bit_d};
            state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign pi0_o  = pi0_q;
  assign busy_o = pend_q || (state_q == Run);

endmodule
`default_nettype wire

FILE: src/bmtp_front.sv
`default_nettype none
module bmtp_front import bmtp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic [AgeWidth-1:0] start_age_i,
  input  wire logic [AgeWidth-1:0] end_age_i,
  input  wire logic [AgeWidth-1:0] rate_scale_i,
  input  wire logic                busy_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output logic [64-FRAC_BITS:0]    q_data_o
);

  localparam int TW = 64 - FRAC_BITS;

  logic                v1_q, v2_q, c1_q, c2_q;
  logic [AgeWidth-1:0] diff1_q, scale1_q;
  logic [TW-1:0]       t2_q;
  logic                en, accept, clamp;
  logic [63:0]         prod;

  assign en       = !q_full_i;
  assign full_o   = q_full_i || busy_i;
  assign accept   = push_i && !full_o;
  assign clamp    = end_age_i > start_age_i;
  assign prod     = 64'(scale1_q) * 64'(diff1_q);
  assign q_push_o = v2_q && en;
  assign q_data_o = {c2_q, t2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q     <= clamp;
      diff1_q  <= clamp ? '0 : start_age_i - end_age_i;
      scale1_q <= rate_scale_i;
      c2_q     <= c1_q;
      t2_q     <= prod[63:FRAC_BITS];
    end
  end

endmodule
`default_nettype wire

FILE: src/bmtp_back.sv
`default_nettype none
module bmtp_back import bmtp_pkg::*; #(
  parameter int FRAC_BITS       = FracBitsDef,
  parameter int EXP_TABLE_DEPTH = ExpDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 mq_empty_i,
  input  wire logic [64-FRAC_BITS:0] mq_data_i,
  output logic                      mq_pop_o,
  input  wire logic [RateWidth-1:0] q01_i,
  input  wire logic [RateWidth-1:0] q10_i,
  input  wire logic [FRAC_BITS:0]   pi0_i,
  input  wire logic                 of_full_i,
  output logic                      of_push_o,
  output logic [FRAC_BITS:0]        p00_o,
  output logic [FRAC_BITS:0]        p01_o,
  output logic [FRAC_BITS:0]        p10_o,
  output logic [FRAC_BITS:0]        p11_o,
  output status_e                   status_o
);

  localparam int TW   = 64 - FRAC_BITS;
  localparam int LoW  = TW / 2;
  localparam int HiW  = TW - LoW;
  localparam int SumW = RateWidth + 1;
  localparam int PW   = SumW + TW;
  localparam int XW   = FRAC_BITS + 5;
  localparam int IW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int TabN = EXP_TABLE_DEPTH + 1;
  localparam int EW   = FRAC_BITS + 2;
  localparam int AW   = 2 * FRAC_BITS + 3;
  localparam logic [FRAC_BITS:0] One = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef logic [31:0] ftab_t [TabN];
  typedef logic [31:0] itab_t [ExpArgLimit];

  function automatic ftab_t build_frac();
    ftab_t tab;
    for (int k = 0; k < TabN; k++) begin
      tab[k] = exp_series((64'(k) << Iq) / EXP_TABLE_DEPTH);
    end
    return tab;
  endfunction

  function automatic itab_t build_int();
    itab_t       tab;
    ftab_t       ft;
    logic [63:0] p;
    ft     = build_frac();
    tab[0] = 32'd1 << Iq;
    for (int k = 1; k < ExpArgLimit; k++) begin
      p      = (64'(tab[k-1]) * 64'(ft[EXP_TABLE_DEPTH])) >> Iq;
      tab[k] = p[31:0];
    end
    return tab;
  endfunction

  localparam ftab_t FracTab = build_frac();
  localparam itab_t IntTab  = build_int();

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q, c8_q, c9_q, c10_q;
  logic s3_q, s4_q, s5_q, s6_q, s7_q, s8_q;
  logic [TW-1:0]           t1_q;
  logic [SumW+LoW-1:0]     plo2_q;
  logic [SumW+HiW-1:0]     phi2_q;
  logic [XW-1:0]           x3_q;
  logic [4:0]              n4_q;
  logic [IW-1:0]           idx4_q;
  logic [FRAC_BITS-1:0]    r4_q, r5_q;
  logic [31:0]             hi5_q, lo5_q, xn5_q, hi6_q, xn6_q, ef7_q, xn7_q, e308_q;
  logic [31+FRAC_BITS:0]   m6_q;
  logic [EW-1:0]           e9_q;
  logic [AW-1:0]           pa10_q, pb10_q;

  logic [SumW-1:0]         sum;
  logic [PW-1:0]           p_full;
  logic [FRAC_BITS+IW-1:0] fd;
  logic [63:0]             e_prod;
  logic [32:0]             e_rnd;
  logic [FRAC_BITS:0]      pi0, pi1;
  logic [AW-1:0]           ra, rb;
  logic [FRAC_BITS+2:0]    a_w, b_w, pi0x, pi1x;
  logic [FRAC_BITS:0]      a, b;
  logic                    sum_zero;

  assign adv       = !of_full_i;
  assign mq_pop_o  = adv && !mq_empty_i;
  assign of_push_o = adv && v10_q;

  always_comb begin
    sum      = {1'b0, q01_i} + {1'b0, q10_i};
    sum_zero = (sum == '0);
    p_full   = PW'(plo2_q) + (PW'(phi2_q) << LoW);
    fd       = FRAC_BITS'(x3_q[FRAC_BITS-1:0]) * (FRAC_BITS + IW)'(EXP_TABLE_DEPTH);
    e_prod   = 64'(xn7_q) * 64'(ef7_q);
    e_rnd    = 33'(e308_q) + (33'(1) << (Iq - FRAC_BITS - 1));
    pi0      = (pi0_i > One) ? One : pi0_i;
    pi1      = One - pi0;
    ra       = pa10_q + AW'(One >> 1);
    rb       = pb10_q + AW'(One >> 1);
    pi0x     = (FRAC_BITS + 3)'(pi0);
    pi1x     = (FRAC_BITS + 3)'(pi1);
    a_w      = ra[AW-1:FRAC_BITS];
    b_w      = rb[AW-1:FRAC_BITS];
    a        = (a_w > pi1x) ? pi1 : a_w[FRAC_BITS:0];
    b        = (b_w > pi0x) ? pi0 : b_w[FRAC_BITS:0];
    if (sum_zero) begin
      p00_o    = One;
      p01_o    = '0;
      p10_o    = '0;
      p11_o    = One;
      status_o = StatusRateZero;
    end else begin
      p00_o    = pi0 + a;
      p01_o    = pi1 - a;
      p10_o    = pi0 - b;
      p11_o    = pi1 + b;
      status_o = c10_q ? StatusClamp : StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q} <= '0;
    end else if (adv) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q} <=
        {!mq_empty_i, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // operand and time product
      c1_q   <= mq_data_i[TW];
      t1_q   <= mq_data_i[TW-1:0];
      c2_q   <= c1_q;
      plo2_q <= (SumW + LoW)'(sum) * (SumW + LoW)'(t1_q[LoW-1:0]);
      phi2_q <= (SumW + HiW)'(sum) * (SumW + HiW)'(t1_q[TW-1:LoW]);
      // exponent argument and saturation
      c3_q   <= c2_q;
      s3_q   <= |p_full[PW-1:FRAC_BITS+5];
      x3_q   <= p_full[2*FRAC_BITS+4:FRAC_BITS];
      // split into integer, table index and residue
      c4_q   <= c3_q;
      s4_q   <= s3_q;
      n4_q   <= x3_q[XW-1:FRAC_BITS];
      idx4_q <= fd[FRAC_BITS+IW-1:FRAC_BITS];
      r4_q   <= fd[FRAC_BITS-1:0];
      // table lookups
      c5_q   <= c4_q;
      s5_q   <= s4_q;
      hi5_q  <= FracTab[idx4_q];
      lo5_q  <= FracTab[idx4_q + IW'(1)];
      xn5_q  <= IntTab[n4_q];
      r5_q   <= r4_q;
      // interpolation
      c6_q   <= c5_q;
      s6_q   <= s5_q;
      m6_q   <= (32 + FRAC_BITS)'(hi5_q - lo5_q) * (32 + FRAC_BITS)'(r5_q);
      hi6_q  <= hi5_q;
      xn6_q  <= xn5_q;
      c7_q   <= c6_q;
      s7_q   <= s6_q;
      ef7_q  <= hi6_q - m6_q[31+FRAC_BITS:FRAC_BITS];
      xn7_q  <= xn6_q;
      c8_q   <= c7_q;
      s8_q   <= s7_q;
      e308_q <= e_prod[61:30];
      c9_q   <= c8_q;
      e9_q   <= s8_q ? '0 : e_rnd[Iq-FRAC_BITS+EW-1:Iq-FRAC_BITS];
      // weighted decay terms
      c10_q  <= c9_q;
      pa10_q <= AW'(pi1) * AW'(e9_q);
      pb10_q <= AW'(pi0) * AW'(e9_q);
    end
  end

endmodule
`default_nettype wire

FILE: src/binary_markov_transition_probs_unit.sv
// an accepted item passes the front registers, the item queue, the back pipeline and the result queue
// throughput: one item per cycle while full is low, set by the fully pipelined multiply and table path
// the two sides are decoupled by a 4-entry item queue and a 4-entry result queue
// reset: rates return to 1.0, both queues empty, full stays high
// while the bit-serial divider forms pi0; each rate write repeats that wait
`default_nettype none
module binary_markov_transition_probs_unit import bmtp_pkg::*; #(
  parameter int FRAC_BITS       = FracBitsDef,
  parameter int EXP_TABLE_DEPTH = ExpDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [AgeWidth-1:0]  start_age_i,
  input  wire logic [AgeWidth-1:0]  end_age_i,
  input  wire logic [AgeWidth-1:0]  rate_scale_i,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [RateWidth-1:0] cfg_data_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [FRAC_BITS:0]        prob_stay_zero_o,
  output logic [FRAC_BITS:0]        prob_zero_to_one_o,
  output logic [FRAC_BITS:0]        prob_one_to_zero_o,
  output logic [FRAC_BITS:0]        prob_stay_one_o,
  output logic [1:0]                status_o
);

  localparam int MqW = 65 - FRAC_BITS;
  localparam int OqW = 4 * (FRAC_BITS + 1) + 2;

  logic [RateWidth-1:0] q01_q, q10_q;
  logic [FRAC_BITS:0]   pi0;
  logic                 busy;
  logic                 mq_push, mq_full, mq_pop, mq_empty;
  logic [MqW-1:0]       mq_wdata, mq_rdata;
  logic                 of_push, of_full;
  logic [FRAC_BITS:0]   p00, p01, p10, p11;
  status_e              st;
  logic [OqW-1:0]       oq_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q01_q <= RateWidth'(32'h0001_0000);
      q10_q <= RateWidth'(32'h0001_0000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRate01: q01_q <= cfg_data_i;
        CfgRate10: q10_q <= cfg_data_i;
        default:   q01_q <= q01_q;
      endcase
    end
  end

  bmtp_pidiv #(.FRAC_BITS(FRAC_BITS)) u_pidiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .q01_i   (q01_q),
    .q10_i   (q10_q),
    .pi0_o   (pi0),
    .busy_o  (busy)
  );

  bmtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .start_age_i  (start_age_i),
    .end_age_i    (end_age_i),
    .rate_scale_i (rate_scale_i),
    .busy_i       (busy),
    .q_full_i     (mq_full),
    .q_push_o     (mq_push),
    .q_data_o     (mq_wdata)
  );

  bmtp_fifo #(.WIDTH(MqW), .DEPTH(4)) u_itemq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_wdata),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .data_o  (mq_rdata),
    .empty_o (mq_empty)
  );

  bmtp_back #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mq_empty_i (mq_empty),
    .mq_data_i  (mq_rdata),
    .mq_pop_o   (mq_pop),
    .q01_i      (q01_q),
    .q10_i      (q10_q),
    .pi0_i      (pi0),
    .of_full_i  (of_full),
    .of_push_o  (of_push),
    .p00_o      (p00),
    .p01_o      (p01),
    .p10_o      (p10),
    .p11_o      (p11),
    .status_o   (st)
  );

  bmtp_fifo #(.WIDTH(OqW), .DEPTH(4)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (of_push),
    .data_i  ({p00, p01, p10, p11, st}),
    .full_o  (of_full),
    .pop_i   (pop),
    .data_o  (oq_rdata),
    .empty_o (empty)
  );

  assign {prob_stay_zero_o, prob_zero_to_one_o, prob_one_to_zero_o, prob_stay_one_o,
          status_o} = oq_rdata;

endmodule
`default_nettype wire

FILE: src/bmtp_checker.sv
`default_nettype none
module bmtp_checker import bmtp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic [FRAC_BITS:0] prob_stay_zero_o,
  input wire logic [FRAC_BITS:0] prob_zero_to_one_o,
  input wire logic [FRAC_BITS:0] prob_one_to_zero_o,
  input wire logic [FRAC_BITS:0] prob_stay_one_o,
  input wire logic [1:0]         status_o
);

  localparam logic [FRAC_BITS+1:0] One = (FRAC_BITS + 2)'(1) << FRAC_BITS;

  logic [FRAC_BITS+1:0] row0, row1;

  assign row0 = {1'b0, prob_stay_zero_o} + {1'b0, prob_zero_to_one_o};
  assign row1 = {1'b0, prob_one_to_zero_o} + {1'b0, prob_stay_one_o};

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == StatusOk || status_o == StatusRateZero ||
                status_o == StatusClamp))
    else $error("bad status code");

  a_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> row0 == One)
    else $error("row zero does not sum to one");

  a_row1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> row1 == One)
    else $error("row one does not sum to one");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == StatusRateZero) |->
      (prob_stay_zero_o == One[FRAC_BITS:0] && prob_stay_one_o == One[FRAC_BITS:0]))
    else $error("zero rate sum without identity");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(prob_stay_zero_o) && $stable(status_o)))
    else $error("waiting item changed");

endmodule

bind binary_markov_transition_probs_unit bmtp_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .empty              (empty),
  .pop                (pop),
  .prob_stay_zero_o   (prob_stay_zero_o),
  .prob_zero_to_one_o (prob_zero_to_one_o),
  .prob_one_to_zero_o (prob_one_to_zero_o),
  .prob_stay_one_o    (prob_stay_one_o),
  .status_o           (status_o)
);
`default_nettype wire

FILE: bench/tb_binary_markov_transition_probs_unit.sv
`default_nettype none
module tb_binary_markov_transition_probs_unit;
  import bmtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = FracBitsDef;
  localparam int Depth = ExpDepthDef;
  localparam int TabW = $clog2(Depth + 1);
  localparam int ArgW = $clog2(ExpArgLimit);
  localparam longint unsigned One = 64'd1 << Frac;
  localparam logic [Frac:0] OneP = (Frac + 1)'(One);
  localparam logic [Frac:0] HalfP = (Frac + 1)'(One / 2);
  localparam int CycleLimit = 600000;
  localparam int NumPhases = 9;

  typedef struct packed {
    logic [Frac:0] p00;
    logic [Frac:0] p01;
    logic [Frac:0] p10;
    logic [Frac:0] p11;
    status_e       st;
  } probs_t;

  typedef struct packed {
    logic [31:0] start_age;
    logic [31:0] end_age;
    logic [31:0] scale;
    logic        typed;
    probs_t      want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [AgeWidth-1:0]  start_age = '0;
  logic [AgeWidth-1:0]  end_age = '0;
  logic [AgeWidth-1:0]  rate_scale = '0;
  logic                 cfg_we = 1'b0;
  logic                 cfg_idx = CfgRate01;
  logic [RateWidth-1:0] cfg_data = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [Frac:0]        p00_o, p01_o, p10_o, p11_o;
  logic [1:0]           status_o;

  longint unsigned frac_tab [0:Depth];
  longint unsigned int_tab [0:ExpArgLimit-1];
  longint unsigned q01 = 65536;
  longint unsigned q10 = 65536;
  probs_t          pending_probs [$];
  int              errors = 0;
  int              checked = 0;
  int              items_sent = 0;
  int              cycles = 0;
  bit              no_gaps = 1'b0;
  bit              hold_req = 1'b0;
  int              hold_cnt = 0;
  row_t            rows [$];

  binary_markov_transition_probs_unit dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .push               (push),
    .full               (full),
    .start_age_i        (start_age),
    .end_age_i          (end_age),
    .rate_scale_i       (rate_scale),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .empty              (empty),
    .pop                (pop),
    .prob_stay_zero_o   (p00_o),
    .prob_zero_to_one_o (p01_o),
    .prob_one_to_zero_o (p10_o),
    .prob_stay_one_o    (p11_o),
    .status_o           (status_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // taylor series of exp(-u), q2.30
  function automatic longint unsigned taylor_exp(longint unsigned u);
    longint          acc;
    longint unsigned term;
    acc = longint'(1) << Iq;
    term = 64'd1 << Iq;
    for (int i = 1; i < 40; i++) begin
      term = ((term * u) >> Iq) / longint'(i);
      if (term == 0) break;
      if (i % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  function automatic longint unsigned neg_exp(longint unsigned x);
    longint unsigned n, fd, idx, idx1, r, hi, lo, ef, e30;
    n = (x >> Frac) % ExpArgLimit;
    fd = (x & (One - 1)) * Depth;
    idx = (fd >> Frac) % Depth;
    idx1 = idx + 1;
    r = fd & (One - 1);
    hi = frac_tab[idx[TabW-1:0]];
    lo = frac_tab[idx1[TabW-1:0]];
    ef = hi - (((hi - lo) * r) >> Frac);
    e30 = (int_tab[n[ArgW-1:0]] * ef) >> Iq;
    return (e30 + (64'd1 << (Iq - Frac - 1))) >> (Iq - Frac);
  endfunction

  function automatic probs_t predict_probs(logic [31:0] s, logic [31:0] e, logic [31:0] k);
    longint unsigned sum, diff, t, ex, pi0, pi1, a, b;
    longint unsigned lim;
    probs_t          p;
    lim = longint'(ExpArgLimit) << Frac;
    sum = q01 + q10;
    p.st = StatusOk;
    if (e > s) begin
      diff = 0;
      p.st = StatusClamp;
    end else begin
      diff = s - e;
    end
    if (sum == 0) begin
      p.p00 = OneP;
      p.p01 = '0;
      p.p10 = '0;
      p.p11 = OneP;
      p.st = StatusRateZero;
      return p;
    end
    t = (longint'(k) * diff) >> Frac;
    if (t != 0 && sum > (lim - 1) / t) ex = 0;
    else ex = neg_exp((sum * t) >> Frac);
    pi0 = ((q10 << Frac) + (sum >> 1)) / sum;
    if (pi0 > One) pi0 = One;
    pi1 = One - pi0;
    a = (pi1 * ex + (One >> 1)) >> Frac;
    b = (pi0 * ex + (One >> 1)) >> Frac;
    if (a > pi1) a = pi1;
    if (b > pi0) b = pi0;
    p.p00 = (Frac + 1)'(pi0 + a);
    p.p01 = (Frac + 1)'(pi1 - a);
    p.p10 = (Frac + 1)'(pi0 - b);
    p.p11 = (Frac + 1)'(pi1 + b);
    return p;
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      pop = 1'b0;
    end else if (no_gaps) begin
      pop = 1'b1;
    end else if ($urandom_range(0, 99) < 8) begin
      pop = 1'b0;
      hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      pop = 1'b1;
    end
  end

  always @(posedge clk) begin
    probs_t w;
    if (rst_n && pop && !empty) begin
      if (pending_probs.size() == 0) begin
        $error("result with no item waiting");
        errors++;
      end else begin
        w = pending_probs.pop_front();
        checked++;
        if (p00_o !== w.p00) begin
          $error("prob_stay_zero exp %0d got %0d", w.p00, p00_o);
          errors++;
        end
        if (p01_o !== w.p01) begin
          $error("prob_zero_to_one exp %0d got %0d", w.p01, p01_o);
          errors++;
        end
        if (p10_o !== w.p10) begin
          $error("prob_one_to_zero exp %0d got %0d", w.p10, p10_o);
          errors++;
        end
        if (p11_o !== w.p11) begin
          $error("prob_stay_one exp %0d got %0d", w.p11, p11_o);
          errors++;
        end
        if (status_o !== w.st) begin
          $error("status exp %0d got %0d", w.st, status_o);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      push = 1'b0;
    end
  endtask

  task automatic send_item(logic [31:0] s, logic [31:0] e, logic [31:0] k,
                           bit typed, probs_t want);
    probs_t p;
    @(negedge clk);
    push = 1'b1;
    start_age = s;
    end_age = e;
    rate_scale = k;
    do @(posedge clk); while (full);
    p = typed ? want : predict_probs(s, e, k);
    pending_probs = {pending_probs, p};
    items_sent++;
    idle_cycles(pick_gap());
  endtask

  task automatic drain();
    idle_cycles(1);
    while (pending_probs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rate(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CfgRate01) q01 = 64'(val);
    else q10 = 64'(val);
  endtask

  task automatic add_row(logic [31:0] s, logic [31:0] e, logic [31:0] k, bit typed,
                         logic [Frac:0] a, logic [Frac:0] b, logic [Frac:0] c,
                         logic [Frac:0] d, status_e st);
    row_t r;
    r.start_age = s;
    r.end_age = e;
    r.scale = k;
    r.typed = typed;
    r.want = '{a, b, c, d, st};
    rows = {rows, r};
  endtask

  initial begin
    logic [31:0] s, e, k, r0, r1;
    int          mode;
    for (int i = 0; i <= Depth; i++) frac_tab[i] = taylor_exp((64'(i) << Iq) / Depth);
    int_tab[0] = 64'd1 << Iq;
    for (int i = 1; i < ExpArgLimit; i++) int_tab[i] = (int_tab[i-1] * frac_tab[Depth]) >> Iq;

    add_row(32'h0, 32'h0, 32'h0, 1'b1, OneP, '0, '0, OneP, StatusOk);
    add_row(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, OneP, '0, '0, OneP, StatusClamp);
    add_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, HalfP, HalfP, HalfP, HalfP, StatusOk);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, OneP, '0, '0, OneP, StatusOk);
    add_row(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0000_8000, 32'h0, 32'h0001_0000, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h000F_FFF0, 32'h0, 32'h0001_0000, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0010_0000, 32'h0, 32'h0001_0000, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0003_0000, 32'h0001_0000, 32'h0, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h5555_5555, 32'h2AAA_AAAA, 32'h0000_0001, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'hAAAA_AAAA, 32'hAAAA_AAA0, 32'h5555_5555, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0000_0001, 32'h0000_0002, 32'h0001_0000, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0000_0001, 32'h0, 32'h0000_0001, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0002_3456, 32'h0000_1234, 32'h0000_C000, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0000_0020, 32'h0, 32'h0000_8000, 1'b0, '0, '0, '0, '0, StatusOk);
    add_row(32'h0000_0040, 32'h0, 32'h0001_0000, 1'b0, '0, '0, '0, '0, StatusOk);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_item(rows[i].start_age, rows[i].end_age, rows[i].scale,
                                rows[i].typed, rows[i].want);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin r0 = 32'h0; r1 = 32'h0; end
        1: begin r0 = 32'hFFFF_FFFF; r1 = 32'hFFFF_FFFF; end
        2: begin r0 = 32'h0; r1 = 32'hFFFF_FFFF; end
        3: begin r0 = 32'hFFFF_FFFF; r1 = 32'h0; end
        4: begin r0 = 32'h0001_0000; r1 = 32'h0; end
        5: begin r0 = $urandom(); r1 = $urandom(); end
        default: begin
          r0 = $urandom_range(0, 32'h4_0000);
          r1 = $urandom_range(0, 32'h4_0000);
        end
      endcase
      write_rate(CfgRate01, r0);
      write_rate(CfgRate10, r1);
      no_gaps = (ph == 6);
      for (int n = 0; n < 88; n++) begin
        if (ph == 7 && n == 10) hold_req = 1'b1;
        if (ph == 8 && n == 40) drain();
        s = $urandom();
        k = $urandom_range(0, 32'h2_0000);
        mode = $urandom_range(0, 9);
        if (mode < 6) e = s - $urandom_range(0, 32'h8_0000);
        else if (mode < 8) begin
          e = $urandom();
          k = $urandom();
        end else e = s + $urandom_range(1, 32'h10_0000);
        send_item(s, e, k, 1'b0, '0);
      end
      drain();
    end

    repeat (30) @(posedge clk);
    $display("%0d items over %0d rate settings, %0d results checked", items_sent,
             NumPhases + 1, checked);
    $display("covered clamp, zero rate sum, saturation, extreme rates, long output stall");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
src/bmtp_pkg.sv
src/bmtp_fifo.sv
src/bmtp_pidiv.sv
src/bmtp_front.sv
src/bmtp_back.sv
src/binary_markov_transition_probs_unit.sv
src/bmtp_checker.sv
bench/tb_binary_markov_transition_probs_unit.sv
